/* rtl/core/b64e_pkg.sv */
// Shared types, constants and the character map of the base64 stream encoder.
`timescale 1ns / 1ps
package b64e_pkg;

  localparam int unsigned CapW  = 13;
  localparam int unsigned CntW  = 13;
  localparam logic [CapW-1:0] CapReset = 13'd96;
  localparam logic [CntW:0]   Margin   = 14'd5;
  localparam logic [7:0]      PadChar  = 8'h3D;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      out_char;
    logic            char_valid;
    logic            run_last;
    logic            message_last;
    logic [CntW-1:0] emitted_count;
  } out_item_t;

  // One closed group handed from the front to the back.
  typedef struct packed {
    logic [23:0]     word;       // bytes left-aligned, first byte on top
    logic [1:0]      nbytes;     // 1..3 real bytes in the group
    logic            emit;       // 0 means end marker only
    logic            last;       // group closes the message
    logic [CntW-1:0] base_count; // characters emitted before this group
  } job_t;

  // Maps a six-bit value to its character in the standard alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] sextet);
    logic [7:0] s;
    s = {2'b00, sextet};
    if (sextet < 6'd26) begin
      b64_char = 8'h41 + s;
    end else if (sextet < 6'd52) begin
      b64_char = 8'h61 + (s - 8'd26);
    end else if (sextet < 6'd62) begin
      b64_char = 8'h30 + (s - 8'd52);
    end else if (sextet == 6'd62) begin
      b64_char = 8'h2B;
    end else begin
      b64_char = 8'h2F;
    end
  endfunction

endpackage

/* rtl/core/b64e_front.sv */
// Front end: collects bytes into groups, applies the capacity check and issues jobs.
`timescale 1ns / 1ps
module b64e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [b64e_pkg::CapW-1:0] cfg_data,
  input  logic               in_valid,
  input  b64e_pkg::in_item_t in_data,
  output logic               in_ready,
  input  logic               q_full,
  output logic               q_push,
  output b64e_pkg::job_t     q_job
);
  import b64e_pkg::*;

  logic [CapW-1:0] cap_r;
  logic [15:0]     pend_r, pend_nxt;
  logic [1:0]      pcnt_r, pcnt_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            drop_r, drop_nxt;
  logic            accept, closes, emit;
  logic [1:0]      nb;
  logic [23:0]     aligned;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    nb = (pcnt_r == 2'd3) ? 2'd3 : pcnt_r + 2'd1;
    closes = (nb == 2'd3) || in_data.message_end;
    case (nb)
      2'd1:    aligned = {in_data.data_byte, 16'h0000};
      2'd2:    aligned = {pend_r[7:0], in_data.data_byte, 8'h00};
      default: aligned = {pend_r, in_data.data_byte};
    endcase
    emit = !drop_r && (({1'b0, cnt_r} + Margin) < {1'b0, cap_r});

    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    q_push   = 1'b0;
    if (accept) begin
      if (!closes) begin
        pend_nxt = {pend_r[7:0], in_data.data_byte};
        pcnt_nxt = nb;
      end else begin
        pend_nxt = '0;
        pcnt_nxt = '0;
        q_push   = emit || in_data.message_end;
        if (emit) begin
          cnt_nxt = cnt_r + CntW'(4);
        end else begin
          drop_nxt = 1'b1;
        end
        if (in_data.message_end) begin
          cnt_nxt  = '0;
          drop_nxt = 1'b0;
        end
      end
    end

    q_job.word       = aligned;
    q_job.nbytes     = nb;
    q_job.emit       = emit;
    q_job.last       = in_data.message_end;
    q_job.base_count = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CapReset;
      pend_r <= '0;
      pcnt_r <= '0;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

/* rtl/core/b64e_queue.sv */
// Two-entry job queue between the front end and the character emitter.
`timescale 1ns / 1ps
module b64e_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output b64e_pkg::job_t head_job
);
  import b64e_pkg::*;

  job_t       mem_r [QueueDepth];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'(QueueDepth));
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/core/b64e_back.sv */
// Back end: registers each job's characters or end marker, one per unstalled cycle.
`timescale 1ns / 1ps
module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  b64e_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_item_t out_data
);
  import b64e_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  out_item_t  out_r, item;
  logic       load, final_res;
  logic [5:0] sextet;
  logic       pad;

  assign load      = head_valid && (!out_valid_r || out_ready);
  assign final_res = !head_job.emit || (idx_r == 2'd3);
  assign pop       = load && final_res;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (idx_r)
      2'd0:    sextet = head_job.word[23:18];
      2'd1:    sextet = head_job.word[17:12];
      2'd2:    sextet = head_job.word[11:6];
      default: sextet = head_job.word[5:0];
    endcase
    pad = ((idx_r == 2'd2) && (head_job.nbytes < 2'd2)) ||
          ((idx_r == 2'd3) && (head_job.nbytes < 2'd3));
    if (head_job.emit) begin
      item.out_char      = pad ? PadChar : b64_char(sextet);
      item.char_valid    = 1'b1;
      item.emitted_count = head_job.base_count + CntW'(idx_r) + CntW'(1);
    end else begin
      item.out_char      = 8'h00;
      item.char_valid    = 1'b0;
      item.emitted_count = head_job.base_count;
    end
    item.run_last     = final_res;
    item.message_last = final_res && head_job.last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= final_res ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/base64_stream_encoder.sv */
// A group-closing byte is written into the queue as a job when it is accepted; the
// emitter then loads its first character from the queue head into the output register.
// The emitter writes one character per cycle while the receiver takes them, and so sets
// the sustained input rate, since each group of three bytes yields four characters.
// Bytes that only fill the holding register are taken every cycle while the queue has room.
// Reset (rst_n, synchronous, active low) empties the queue and output register,
// clears the holding register and message counters, and sets capacity to 96.
`timescale 1ns / 1ps
module base64_stream_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [b64e_pkg::CapW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64e_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_item_t out_data
);
  import b64e_pkg::*;

  // Capacity register always writable; the user must change it only while idle.
  assign cfg_ready = 1'b1;

  logic q_full, q_push, q_pop, q_head_valid;
  job_t q_job, q_head;

  // The front end accepts a byte every cycle while the queue has room. A byte that
  // closes a group (third byte or message end) is checked against the capacity; a kept
  // group becomes a job of four characters, a dropped final group an end marker job.
  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // The queue lets the front keep taking bytes while the emitter is busy or stalled.
  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  // While the output is not stalled, the emitter walks each job and writes one result
  // transaction per cycle into the output register, refilled in the same cycle it drains.
  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef NO_ASSERTIONS
  // The end of a message always closes the run of its transaction.
  a_msg_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.message_last |-> out_data.run_last)
    else $error("message_last without run_last");

  // An end marker only ever appears as the last result of a message.
  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.char_valid |-> out_data.message_last)
    else $error("end marker not at message end");

  // A character result always counts itself.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.char_valid |-> out_data.emitted_count != '0)
    else $error("character with zero emitted count");

  // A popped job must have been present in the queue.
  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");
`endif

endmodule

/* tb/b64e_checker.sv */
// Checker for the base64 stream encoder: predicts each character and compares results.
`timescale 1ns / 1ps
module b64e_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [b64e_pkg::CapW-1:0]    cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  b64e_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  b64e_pkg::out_item_t          out_data,
  output int                           errors,
  output int                           outstanding
);

  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [b64e_pkg::CapW-1:0] capacity;
  logic [15:0]               hold_bytes;
  logic [1:0]                hold_count;
  logic [b64e_pkg::CntW-1:0] msg_chars;
  logic                      drop_flag;
  b64e_pkg::out_item_t       expected_chars[$];
  int                        mismatch_count = 0;
  int                        chars_waiting = 0;

  assign errors      = mismatch_count;
  assign outstanding = chars_waiting;

  function automatic logic [7:0] sextet_char(input logic [5:0] sextet);
    int idx;
    idx = sextet;
    sextet_char = Alphabet[511 - 8*idx -: 8];
  endfunction

  // Queues the characters that one accepted byte produces, if any.
  task automatic encode_byte(input b64e_pkg::in_item_t item);
    int unsigned         nbytes;
    logic [23:0]         group;
    b64e_pkg::out_item_t r;
    nbytes = hold_count + 1;
    group  = {hold_bytes, item.data_byte};
    if (nbytes < 3 && !item.message_end) begin
      hold_bytes = group[15:0];
      hold_count = nbytes[1:0];
      return;
    end
    group = group << (8 * (3 - nbytes));
    if (!drop_flag && (int'(msg_chars) + 5 < int'(capacity))) begin
      for (int k = 0; k < 4; k++) begin
        msg_chars      = msg_chars + 1'b1;
        r.out_char     = (k > nbytes) ? b64e_pkg::PadChar : sextet_char(group[23-6*k -: 6]);
        r.char_valid   = 1'b1;
        r.run_last     = (k == 3);
        r.message_last = (k == 3) && item.message_end;
        r.emitted_count = msg_chars;
        expected_chars.push_back(r);
      end
    end else begin
      drop_flag = 1'b1;
      if (item.message_end) begin
        r.out_char      = 8'h00;
        r.char_valid    = 1'b0;
        r.run_last      = 1'b1;
        r.message_last  = 1'b1;
        r.emitted_count = msg_chars;
        expected_chars.push_back(r);
      end
    end
    hold_bytes = 16'h0000;
    hold_count = 2'd0;
    if (item.message_end) begin
      msg_chars = '0;
      drop_flag = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    b64e_pkg::out_item_t want;
    if (!rst_n) begin
      capacity   = b64e_pkg::CapReset;
      hold_bytes = 16'h0000;
      hold_count = 2'd0;
      msg_chars  = '0;
      drop_flag  = 1'b0;
      expected_chars.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("result with nothing expected: char %02h valid %0b", out_data.out_char,
                 out_data.char_valid);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            $error("out_char: expected %02h, got %02h", want.out_char, out_data.out_char);
            mismatch_count++;
          end
          if (out_data.char_valid !== want.char_valid) begin
            $error("char_valid: expected %0b, got %0b", want.char_valid, out_data.char_valid);
            mismatch_count++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_data.run_last);
            mismatch_count++;
          end
          if (out_data.message_last !== want.message_last) begin
            $error("message_last: expected %0b, got %0b", want.message_last,
                   out_data.message_last);
            mismatch_count++;
          end
          if (out_data.emitted_count !== want.emitted_count) begin
            $error("emitted_count: expected %0d, got %0d", want.emitted_count,
                   out_data.emitted_count);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
      end
      if (in_valid && in_ready) begin
        encode_byte(in_data);
      end
    end
    chars_waiting <= expected_chars.size();
  end

endmodule

/* tb/tb_base64_stream_encoder.sv */
// Testbench top for the base64 stream encoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_base64_stream_encoder;

  // Length of the long receiver hold-off that backs the block up into its input.
  localparam int LongHold = 300;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [b64e_pkg::CapW-1:0] cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  b64e_pkg::in_item_t        in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  b64e_pkg::out_item_t       out_data;

  int errors;
  int outstanding;

  // Flow control knobs. The sender's idle rate is only used by the stimulus process;
  // the receiver's stall rate and hold request are handed over with nonblocking writes.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  base64_stream_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  b64e_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver. A change of hold_seq starts a long hold-off counted here; otherwise
  // out_ready follows the current stall rate, one random draw per cycle.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= LongHold;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one byte and returns at the edge where the transaction completes.
  // Gaps are inserted before the byte, so valid is never dropped and raised in one step.
  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: data, message_end: last};
    do @(posedge clk); while (!in_ready);
  endtask

  // A whole message of random content; zero and all-ones bytes show up more often.
  task automatic send_message(input int len);
    logic [7:0] b;
    int         pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
      send_byte(b, i == len - 1);
    end
  endtask

  // Capacity is only written once the block has drained. The first edge lets the
  // checker count the last accepted byte before the outstanding count is trusted.
  task automatic write_capacity(input logic [b64e_pkg::CapW-1:0] cap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: a capacity, an idling pattern and a number of bytes. Lengths are
  // mostly short, with enough long messages to run into small capacities.
  task automatic run_phase(input logic [b64e_pkg::CapW-1:0] cap, input int idle_pct,
                           input int stall, input int quota, input bit squeeze);
    int sent;
    int len;
    int r;
    write_capacity(cap);
    send_idle_pct = idle_pct;
    stall_pct <= stall;
    if (squeeze) begin
      hold_seq <= hold_seq + 1;
    end
    sent = 0;
    while (sent < quota) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(9, 1);
      end else if (r < 95) begin
        len = $urandom_range(40, 10);
      end else begin
        len = $urandom_range(80, 41);
      end
      send_message(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset capacity of 96, no idling on either side.
    // One byte: two characters and two pads.
    send_byte(8'h00, 1'b1);
    // Two bytes of all ones: three characters and one pad.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Every sextet is 62, the plus character.
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    // Every sextet is 63, then a one-byte tail.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);

    // Capacity of six leaves room for exactly one group; the second and the final
    // group are dropped, and the message closes with an end marker.
    write_capacity(13'd6);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);

    // Capacity of one: nothing fits, only the end marker comes out.
    write_capacity(13'd1);
    send_byte(8'h01, 1'b1);

    // Dropping sticks for the rest of the message, even after the capacity is raised
    // in the middle of it.
    write_capacity(13'd6);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b0);
    write_capacity(13'd4096);
    send_byte(8'h07, 1'b1);

    // Random phases: no idling, sender idle, receiver stalling, both, then a long
    // receiver hold-off while the sender keeps pushing, and a capacity above the range.
    run_phase(13'd96,   0,  0,  75, 1'b0);
    run_phase(13'd4096, 53, 0,  75, 1'b0);
    run_phase(13'd20,   0,  53, 75, 1'b0);
    run_phase(13'd1,    34, 34, 60, 1'b0);
    run_phase(13'd64,   34, 34, 75, 1'b0);
    run_phase(13'd4096, 0,  0,  40, 1'b1);
    run_phase(13'd8191, 0,  0,  30, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* base64_stream_encoder.f */
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder.sv
tb/b64e_checker.sv
tb/tb_base64_stream_encoder.sv
